### design/fib_fd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fast-doubling Fibonacci package
// Shared widths, microcode word layout and the microcode ROM contents.
// ----------------------------------------------------------------------------
package fib_fd_pkg;

    // Default sizes and fixed port widths.
    localparam int DEF_INDEX_BITS = 31;
    localparam int DEF_VALUE_BITS = 64;
    localparam int IDX_DATA_BITS  = 32;
    localparam int FIB_DATA_BITS  = 64;

    // Step counter of the microcode program.
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_LOOP = 4'd0;
    localparam logic [STEP_W-1:0] STEP_SQ_A1 = 4'd1;
    localparam logic [STEP_W-1:0] STEP_SQ_A2 = 4'd2;
    localparam logic [STEP_W-1:0] STEP_SQ_B1 = 4'd3;
    localparam logic [STEP_W-1:0] STEP_SQ_B2 = 4'd4;
    localparam logic [STEP_W-1:0] STEP_EV_1 = 4'd5;
    localparam logic [STEP_W-1:0] STEP_EV_2 = 4'd6;
    localparam logic [STEP_W-1:0] STEP_EV_3 = 4'd7;
    localparam logic [STEP_W-1:0] STEP_UPDATE = 4'd8;

    // First multiplier operand: F(k) or F(k+1).
    typedef enum logic {
        XS_A = 1'b0,
        XS_B = 1'b1
    } t_xsrc;

    // Second multiplier operand: F(k), F(k+1) or 2F(k+1)-F(k).
    typedef enum logic [1:0] {
        YS_A = 2'd0,
        YS_B = 2'd1,
        YS_C = 2'd2
    } t_ysrc;

    // Accumulator operation on the registered partial product.
    typedef enum logic [1:0] {
        AO_NONE = 2'd0,
        AO_LOAD = 2'd1,
        AO_ADD  = 2'd2
    } t_acc_op;

    // One microcode word.
    typedef struct packed {
        logic              mul_en;    // issue a partial product
        t_xsrc             x_src;
        logic              x_hi;      // take upper half of x
        t_ysrc             y_src;
        logic              y_hi;      // take upper half of y
        t_acc_op           acc_op;
        logic              acc_sh;    // shift product up by half a word
        logic              acc_dbl;   // double the product
        logic              save_odd;  // capture accumulator as F(2k+1)
        logic              calc_c;    // form 2F(k+1)-F(k)
        logic              update;    // write back the new pair
        logic              jmp_en;    // loop back while index bits remain
        logic [STEP_W-1:0] jmp_addr;
    } t_uword;

    // Control handed from the sequencer to the datapath.
    typedef struct packed {
        t_uword uw;
        logic   init;     // load the starting pair (0, 1)
        logic   bit_set;  // current index bit
    } t_dp_ctrl;

    // Microcode ROM. One pass covers one index bit: the two squares give
    // F(2k+1), the product with 2F(k+1)-F(k) gives F(2k). Each wide product
    // is built from half-width partial products, wrapping at the word size.
    function automatic t_uword ucode_rom(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '0;
        unique case (step)
            STEP_LOOP: begin
                w.calc_c = 1'b1;
                w.mul_en = 1'b1; w.x_src = XS_A; w.y_src = YS_A;
            end
            STEP_SQ_A1: begin
                w.acc_op = AO_LOAD;
                w.mul_en = 1'b1; w.x_src = XS_A; w.y_src = YS_A; w.y_hi = 1'b1;
            end
            STEP_SQ_A2: begin
                w.acc_op = AO_ADD; w.acc_sh = 1'b1; w.acc_dbl = 1'b1;
                w.mul_en = 1'b1; w.x_src = XS_B; w.y_src = YS_B;
            end
            STEP_SQ_B1: begin
                w.acc_op = AO_ADD;
                w.mul_en = 1'b1; w.x_src = XS_B; w.y_src = YS_B; w.y_hi = 1'b1;
            end
            STEP_SQ_B2: begin
                w.acc_op = AO_ADD; w.acc_sh = 1'b1; w.acc_dbl = 1'b1;
                w.mul_en = 1'b1; w.x_src = XS_A; w.y_src = YS_C;
            end
            STEP_EV_1: begin
                w.save_odd = 1'b1;
                w.acc_op = AO_LOAD;
                w.mul_en = 1'b1; w.x_src = XS_A; w.y_src = YS_C; w.y_hi = 1'b1;
            end
            STEP_EV_2: begin
                w.acc_op = AO_ADD; w.acc_sh = 1'b1;
                w.mul_en = 1'b1; w.x_src = XS_A; w.x_hi = 1'b1; w.y_src = YS_C;
            end
            STEP_EV_3: begin
                w.acc_op = AO_ADD; w.acc_sh = 1'b1;
            end
            STEP_UPDATE: begin
                w.update = 1'b1;
                w.jmp_en = 1'b1; w.jmp_addr = STEP_LOOP;
            end
            default: begin
                w = '0;
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

### design/fib_fd_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fast-doubling Fibonacci sequencer
// Step counter, index bit counter and microcode ROM that drive the datapath.
// ----------------------------------------------------------------------------
module fib_fd_seq #(
    parameter int INDEX_BITS = fib_fd_pkg::DEF_INDEX_BITS
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,     // request accepted
    input  wire  [INDEX_BITS-1:0]      i_index,
    input  wire                        i_out_free,  // result register can load
    output logic                       o_idle,
    output logic                       o_done,      // result is final this cycle
    output fib_fd_pkg::t_dp_ctrl       o_ctrl
);
    import fib_fd_pkg::*;

    localparam int BIT_W = (INDEX_BITS > 1) ? $clog2(INDEX_BITS) : 1;
    localparam logic [BIT_W-1:0] BIT_TOP = BIT_W'(INDEX_BITS - 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } t_state;

    t_state                r_state, n_state;
    logic [STEP_W-1:0]     r_step, n_step;
    logic [BIT_W-1:0]      r_bit, n_bit;
    logic [INDEX_BITS-1:0] r_index;
    t_uword                w_uw;

    assign w_uw = ucode_rom(r_step);

    // Next state, step and bit position.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_bit   = r_bit;
        o_done  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_RUN;
                    n_step  = STEP_LOOP;
                    n_bit   = BIT_TOP;
                end
            end
            ST_RUN: begin
                if (w_uw.jmp_en) begin
                    if (r_bit != '0) begin
                        n_bit  = r_bit - 1'b1;
                        n_step = w_uw.jmp_addr;
                    end else begin
                        n_state = ST_DONE;
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= STEP_LOOP;
            r_bit   <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_bit   <= n_bit;
        end
    end

    // The index is held for the whole run.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_index <= i_index;
        end
    end

    // Microcode word is only live while running.
    always_comb begin
        o_ctrl         = '0;
        o_ctrl.init    = (r_state == ST_IDLE) && i_start;
        o_ctrl.bit_set = r_index[r_bit];
        if (r_state == ST_RUN) begin
            o_ctrl.uw = w_uw;
        end
    end

    assign o_idle = (r_state == ST_IDLE);

endmodule
`default_nettype wire

### design/fib_fd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fast-doubling Fibonacci datapath
// Pair registers, one half-width multiplier and a wrapping accumulator.
// ----------------------------------------------------------------------------
module fib_fd_datapath #(
    parameter int VALUE_BITS = fib_fd_pkg::DEF_VALUE_BITS
) (
    input  wire                       i_clk,
    input  fib_fd_pkg::t_dp_ctrl      i_ctrl,
    output logic [VALUE_BITS-1:0]     o_fib
);
    import fib_fd_pkg::*;

    localparam int HALF = (VALUE_BITS + 1) / 2;

    logic [VALUE_BITS-1:0] r_a;     // F(k)
    logic [VALUE_BITS-1:0] r_b;     // F(k+1)
    logic [VALUE_BITS-1:0] r_c;     // 2F(k+1) - F(k)
    logic [VALUE_BITS-1:0] r_odd;   // F(2k+1)
    logic [VALUE_BITS-1:0] r_acc;
    logic [2*HALF-1:0]     r_prod;

    logic [VALUE_BITS-1:0] w_xw, w_yw, w_add;
    logic [HALF-1:0]       w_x, w_y;

    // Operand selection and half select.
    always_comb begin
        w_xw = (i_ctrl.uw.x_src == XS_B) ? r_b : r_a;
        case (i_ctrl.uw.y_src)
            YS_A:    w_yw = r_a;
            YS_B:    w_yw = r_b;
            YS_C:    w_yw = r_c;
            default: w_yw = r_a;
        endcase
        w_x = i_ctrl.uw.x_hi ? HALF'(w_xw >> HALF) : w_xw[HALF-1:0];
        w_y = i_ctrl.uw.y_hi ? HALF'(w_yw >> HALF) : w_yw[HALF-1:0];
    end

    // Registered partial product.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.uw.mul_en) begin
            r_prod <= (2*HALF)'(w_x) * (2*HALF)'(w_y);
        end
    end

    // Product aligned for the accumulator; bits above the word drop out.
    always_comb begin
        w_add = VALUE_BITS'(r_prod);
        if (i_ctrl.uw.acc_sh) begin
            w_add = w_add << HALF;
        end
        if (i_ctrl.uw.acc_dbl) begin
            w_add = w_add << 1;
        end
    end

    // Accumulator.
    always_ff @(posedge i_clk) begin
        case (i_ctrl.uw.acc_op)
            AO_LOAD: r_acc <= w_add;
            AO_ADD:  r_acc <= r_acc + w_add;
            default: r_acc <= r_acc;
        endcase
    end

    // Pair and helper registers.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.uw.calc_c) begin
            r_c <= (r_b << 1) - r_a;
        end
        if (i_ctrl.uw.save_odd) begin
            r_odd <= r_acc;
        end
        if (i_ctrl.init) begin
            r_a <= '0;
            r_b <= VALUE_BITS'(1);
        end else if (i_ctrl.uw.update) begin
            // The accumulator now holds F(2k); a set bit steps the pair on.
            if (i_ctrl.bit_set) begin
                r_a <= r_odd;
                r_b <= r_acc + r_odd;
            end else begin
                r_a <= r_acc;
                r_b <= r_odd;
            end
        end
    end

    assign o_fib = r_a;

endmodule
`default_nettype wire

### design/fibonacci_fast_doubling_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Fast-doubling Fibonacci, top level
// Returns F(n) modulo 2^VALUE_BITS for each index request on the input stream.
// ----------------------------------------------------------------------------
// Each request carries an index n; the block returns one result holding
// F(n) wrapped to VALUE_BITS bits, zero above. All INDEX_BITS index bits are
// scanned from the top down, one fast-doubling pass per bit, and each pass
// steps the microcode from STEP_LOOP to STEP_UPDATE around a single
// half-width multiplier that forms seven partial products. The block works
// on one request at a time, so no new request is accepted until the result
// of the last one has moved to the output register. A finished result waits
// in the output register, and the next request is taken meanwhile.
module fibonacci_fast_doubling_top #(
    parameter int INDEX_BITS = fib_fd_pkg::DEF_INDEX_BITS,
    parameter int VALUE_BITS = fib_fd_pkg::DEF_VALUE_BITS
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  wire  [fib_fd_pkg::IDX_DATA_BITS-1:0]  i_s_axis_tdata,  // [30:0] index
    output logic                                  o_m_axis_tvalid,
    input  wire                                   i_m_axis_tready,
    output logic [fib_fd_pkg::FIB_DATA_BITS-1:0]  o_m_axis_tdata   // [63:0] fib_value
);
    import fib_fd_pkg::*;

    logic                     w_idle, w_done, w_start, w_out_free;
    t_dp_ctrl                 w_ctrl;
    logic [VALUE_BITS-1:0]    w_fib;
    logic                     r_out_valid;
    logic [FIB_DATA_BITS-1:0] r_out_data;

    // No request is taken while reset is held.
    assign o_s_axis_tready = w_idle && i_rst_n;
    assign w_start         = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    fib_fd_seq #(
        .INDEX_BITS (INDEX_BITS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_index    (i_s_axis_tdata[INDEX_BITS-1:0]),
        .i_out_free (w_out_free),
        .o_idle     (w_idle),
        .o_done     (w_done),
        .o_ctrl     (w_ctrl)
    );

    fib_fd_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk  (i_clk),
        .i_ctrl (w_ctrl),
        .o_fib  (w_fib)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_data <= FIB_DATA_BITS'(w_fib);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule
`default_nettype wire

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fast-doubling Fibonacci testbench
// Streams index requests into the block and checks each returned value against
// a bit-accurate fast-doubling predictor. Both stream sides pause at random, and
// the result side once holds off long enough to back the block up.
// ----------------------------------------------------------------------------

// Scoreboard: predicts F(n) mod 2^64 for each accepted request and checks the
// returned values in order.
class fib_scoreboard;
    logic [fib_fd_pkg::FIB_DATA_BITS-1:0] pending_values[$];
    int                                   errors;
    int                                   results_seen;

    function new();
        errors       = 0;
        results_seen = 0;
    endfunction

    // Fast doubling over all index bits, top bit first, wrapping at 64 bits.
    function logic [63:0] fib_of_index(input logic [30:0] n);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] even_term;
        logic [63:0] odd_term;
        a = 64'd0;
        b = 64'd1;
        for (int k = fib_fd_pkg::DEF_INDEX_BITS - 1; k >= 0; k--) begin
            even_term = a * ((b << 1) - a);
            odd_term  = a * a + b * b;
            if (n[k]) begin
                a = odd_term;
                b = even_term + odd_term;
            end else begin
                a = even_term;
                b = odd_term;
            end
        end
        return a;
    endfunction

    function void note_request(input logic [fib_fd_pkg::IDX_DATA_BITS-1:0] tdata);
        pending_values.push_back(fib_of_index(tdata[30:0]));
    endfunction

    function void check_result(input logic [fib_fd_pkg::FIB_DATA_BITS-1:0] tdata);
        logic [fib_fd_pkg::FIB_DATA_BITS-1:0] expected_value;
        results_seen++;
        if (pending_values.size() == 0) begin
            $error("unexpected result: fib_value actual %h", tdata);
            errors++;
        end else begin
            expected_value = pending_values.pop_front();
            if (tdata !== expected_value) begin
                $error("fib_value mismatch: expected %h, actual %h",
                       expected_value, tdata);
                errors++;
            end
        end
    endfunction
endclass

module tb;
    import fib_fd_pkg::*;

    localparam int  RANDOM_REQUESTS = 1380;
    localparam int  HOLD_AFTER      = 150;      // results before the long hold-off
    localparam int  HOLD_CYCLES     = 3000;
    localparam int  DRAIN_CYCLES    = 300;      // a little over one request's latency
    localparam longint CYCLE_LIMIT  = 3000000;

    logic                     i_clk   = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic [IDX_DATA_BITS-1:0] s_tdata  = '0;   // [30:0] index
    logic                     s_tready;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [FIB_DATA_BITS-1:0] m_tdata;         // [63:0] fib_value
    longint                   cycle_count = 0;
    bit                       no_gaps = 1'b0;

    fib_scoreboard fib_sb = new();

    fibonacci_fast_doubling_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    // Free-running clock, 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offers one index request after a random pause and waits for acceptance.
    // The valid stays high between back-to-back requests.
    task automatic send_index(input logic [30:0] index);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, index};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        fib_sb.note_request({1'b0, index});
    endtask

    // Random index: small values, values around the 64-bit wrap, indices with a
    // random top bit, and fully random 31-bit values.
    function automatic logic [30:0] random_index();
        logic [30:0] value;
        int          width;
        case ($urandom_range(0, 3))
            0: value = 31'($urandom_range(0, 100));
            1: value = 31'($urandom_range(85, 100));
            2: begin
                width = $urandom_range(1, 31);
                value = 31'($urandom) & 31'((64'd1 << width) - 1);
                value[width-1] = 1'b1;
            end
            default: value = 31'($urandom);
        endcase
        return value;
    endfunction

    // Result side: random stalls against a waiting result, plus one long
    // hold-off so that requests back up into the block.
    initial begin
        int  wait_cycles;
        bit  held;
        held = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held && fib_sb.results_seen == HOLD_AFTER) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            wait_cycles = no_gaps ? 0 : $urandom_range(0, 10);
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                @(posedge i_clk);
                while (!m_tvalid) @(posedge i_clk);
                repeat (wait_cycles) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
            fib_sb.check_result(m_tdata);
        end
    end

    // Main sequence: reset, directed indices, random indices, drain.
    initial begin
        logic [30:0] directed[$];
        directed = '{31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd10, 31'd46,
                     31'd47, 31'd92, 31'd93, 31'd94, 31'd95, 31'd128,
                     31'h4000_0000, 31'h7FFF_FFFF, 31'h5555_5555, 31'h2AAA_AAAA,
                     31'h0000_FFFF, 31'h7FFF_0000, 31'h0123_4567, 31'h0000_0100};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: extremes, the wrap region and alternating bit patterns.
        foreach (directed[k]) send_index(directed[k]);

        // Random part, in stretches of 50 requests, each run with random idling or, at random, with none.
        for (int k = 0; k < RANDOM_REQUESTS; k++) begin
            if (k % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
            send_index(random_index());
        end
        s_tvalid <= 1'b0;
        no_gaps = 1'b0;

        // Wait for every expected value, then a further latency's worth.
        while (fib_sb.pending_values.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fib_sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
